### rtl/cvf_pkg.sv
// shared types, widths and rounding helpers for the cylinder vortex force core
// no dependencies; imported by every module of the block
package cvf_pkg;

  // fixed point format and data widths
  localparam int FRAC_BITS = 16;
  localparam int W         = 32;
  localparam int DW        = W + 1;          // exact offset width
  localparam int VW        = 49;             // normalizer input width
  localparam int MW        = 30;             // magnitude width after range shift
  localparam int SHW       = $clog2(VW);
  localparam int SUMW      = 2 * MW + 2;     // sum of three squares
  localparam int SQW       = MW + 1;         // square root width
  localparam int REMW      = SQW + 4;        // square root remainder width
  localparam int NUMW      = SQW + FRAC_BITS; // divider dividend width
  localparam int QW        = FRAC_BITS + 1;  // unit component magnitude width
  localparam int UW        = FRAC_BITS + 2;  // signed unit component width
  localparam int PW        = UW + W;         // unit times axis product width

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  // configuration register indexes
  localparam logic [2:0] REG_COEF   = 3'd0;
  localparam logic [2:0] REG_AXIS_X = 3'd1;
  localparam logic [2:0] REG_AXIS_Y = 3'd2;
  localparam logic [2:0] REG_AXIS_Z = 3'd3;
  localparam logic [2:0] REG_CTR_X  = 3'd4;
  localparam logic [2:0] REG_CTR_Y  = 3'd5;
  localparam logic [2:0] REG_CTR_Z  = 3'd6;
  localparam logic [2:0] REG_AXES   = 3'd7;

  typedef struct packed {
    logic signed [W-1:0] coef;
    logic signed [W-1:0] ax;
    logic signed [W-1:0] ay;
    logic signed [W-1:0] az;
    logic signed [W-1:0] cx;
    logic signed [W-1:0] cy;
    logic signed [W-1:0] cz;
    logic [2:0]          en_axes;
  } cfg_t;

  // fields that ride along with each particle
  typedef struct packed {
    logic signed [W-1:0] acc_x;
    logic signed [W-1:0] acc_y;
    logic signed [W-1:0] acc_z;
    logic signed [W-1:0] k;
    logic                degen;
  } side_t;

  // round half away from zero, dropping FRAC_BITS bits
  function automatic logic signed [63:0] rnd_q(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  // clamp to the signed 32 bit range
  function automatic logic signed [W-1:0] sat32(input logic signed [63:0] v);
    logic signed [W-1:0] r;
    if (v > S32_MAX) r = S32_MAX[W-1:0];
    else if (v < S32_MIN) r = S32_MIN[W-1:0];
    else r = v[W-1:0];
    return r;
  endfunction

endpackage

### rtl/cylinder_vortex_force_core.sv
// cylinder vortex force core, top level; uses cvf_pkg, cvf_norm, cvf_proj, cvf_force
// two normalizers of 55 stages each, most of them in the 31 stage square root and
//   the 17 stage divider
// throughput: one word per cycle when not stalled; dead particles dropped at input
// reset: synchronous, clears valid bits and loads the default register values
module cylinder_vortex_force_core import cvf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [W-1:0]        cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_alive,
  input  logic signed [W-1:0] in_pos_x,
  input  logic signed [W-1:0] in_pos_y,
  input  logic signed [W-1:0] in_pos_z,
  input  logic signed [W-1:0] in_strength,
  input  logic signed [W-1:0] in_acc_in_x,
  input  logic signed [W-1:0] in_acc_in_y,
  input  logic signed [W-1:0] in_acc_in_z,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [W-1:0] out_acc_out_x,
  output logic signed [W-1:0] out_acc_out_y,
  output logic signed [W-1:0] out_acc_out_z,
  output logic                out_degenerate
);

  cfg_t cfg_r;

  logic                 en;
  logic                 s1_v_r;
  logic signed [DW-1:0] d_r [3];
  logic signed [63:0]   pk_r;
  logic signed [W-1:0]  acc1_r [3];
  logic                 s2_v_r;
  logic signed [VW-1:0] d2_r [3];
  side_t                side2_r;

  logic                 n1_v;
  logic signed [UW-1:0] n1_vec [3];
  side_t                n1_side;
  logic                 pj_v;
  logic signed [VW-1:0] pj_r [3];
  side_t                pj_side;
  logic                 n2_v;
  logic signed [UW-1:0] n2_vec [3];
  side_t                n2_side;
  logic                 fc_v;
  logic signed [W-1:0]  fc_acc [3];
  logic                 fc_degen;

  logic                 out_v_r;
  logic signed [W-1:0]  out_acc_r [3];
  logic                 out_degen_r;
  logic                 skid_v_r;
  logic signed [W-1:0]  skid_acc_r [3];
  logic                 skid_degen_r;
  logic                 out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef    <= W'(1) <<< FRAC_BITS;
      cfg_r.ax      <= '0;
      cfg_r.ay      <= '0;
      cfg_r.az      <= W'(1) <<< FRAC_BITS;
      cfg_r.cx      <= '0;
      cfg_r.cy      <= '0;
      cfg_r.cz      <= '0;
      cfg_r.en_axes <= 3'b111;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEF:   cfg_r.coef    <= cfg_wdata;
        REG_AXIS_X: cfg_r.ax      <= cfg_wdata;
        REG_AXIS_Y: cfg_r.ay      <= cfg_wdata;
        REG_AXIS_Z: cfg_r.az      <= cfg_wdata;
        REG_CTR_X:  cfg_r.cx      <= cfg_wdata;
        REG_CTR_Y:  cfg_r.cy      <= cfg_wdata;
        REG_CTR_Z:  cfg_r.cz      <= cfg_wdata;
        REG_AXES:   cfg_r.en_axes <= cfg_wdata[2:0];
        default:    ;
      endcase
    end
  end

  // pipeline moves unless the skid stage holds a word
  assign en       = !skid_v_r;
  assign in_stall = !en;

  // offset from centre and strength times coefficient
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid && in_alive;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0]    <= DW'(in_pos_x) - DW'(cfg_r.cx);
      d_r[1]    <= DW'(in_pos_y) - DW'(cfg_r.cy);
      d_r[2]    <= DW'(in_pos_z) - DW'(cfg_r.cz);
      pk_r      <= 64'(in_strength) * 64'(cfg_r.coef);
      acc1_r[0] <= in_acc_in_x;
      acc1_r[1] <= in_acc_in_y;
      acc1_r[2] <= in_acc_in_z;
      for (int i = 0; i < 3; i++) d2_r[i] <= VW'(d_r[i]);
      side2_r.acc_x <= acc1_r[0];
      side2_r.acc_y <= acc1_r[1];
      side2_r.acc_z <= acc1_r[2];
      side2_r.k     <= sat32(rnd_q(pk_r));
      side2_r.degen <= 1'b0;
    end
  end

  cvf_norm u_norm_ofs (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (s2_v_r),
    .in_vec   (d2_r),
    .in_side  (side2_r),
    .out_v    (n1_v),
    .out_vec  (n1_vec),
    .out_side (n1_side)
  );

  cvf_proj u_proj (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .cfg      (cfg_r),
    .in_v     (n1_v),
    .in_u     (n1_vec),
    .in_side  (n1_side),
    .out_v    (pj_v),
    .out_r    (pj_r),
    .out_side (pj_side)
  );

  cvf_norm u_norm_rad (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (pj_v),
    .in_vec   (pj_r),
    .in_side  (pj_side),
    .out_v    (n2_v),
    .out_vec  (n2_vec),
    .out_side (n2_side)
  );

  cvf_force u_force (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cfg       (cfg_r),
    .in_v      (n2_v),
    .in_n      (n2_vec),
    .in_side   (n2_side),
    .out_v     (fc_v),
    .out_acc   (fc_acc),
    .out_degen (fc_degen)
  );

  // output register with skid stage
  assign out_free = !out_v_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_v_r) begin
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end else begin
          out_v_r <= fc_v;
        end
      end else if (en && fc_v) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_v_r) begin
        out_acc_r   <= skid_acc_r;
        out_degen_r <= skid_degen_r;
      end else begin
        out_acc_r   <= fc_acc;
        out_degen_r <= fc_degen;
      end
    end else if (en && fc_v) begin
      skid_acc_r   <= fc_acc;
      skid_degen_r <= fc_degen;
    end
  end

  assign out_valid      = out_v_r;
  assign out_acc_out_x  = out_acc_r[0];
  assign out_acc_out_y  = out_acc_r[1];
  assign out_acc_out_z  = out_acc_r[2];
  assign out_degenerate = out_degen_r;

endmodule

### rtl/cvf_norm.sv
// pipelined vector normalizer: range shift, sum of squares, bit serial
// square root and per lane restoring divide; uses cvf_pkg
module cvf_norm import cvf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_v,
  input  logic signed [VW-1:0] in_vec [3],
  input  side_t                in_side,
  output logic                 out_v,
  output logic signed [UW-1:0] out_vec [3],
  output side_t                out_side
);

  typedef struct packed {
    logic               v;
    side_t              side;
    logic [2:0]         sgn;
    logic [2:0][VW-1:0] mag;
    logic [VW-1:0]      mx;
  } s1_t;

  typedef struct packed {
    logic               v;
    side_t              side;
    logic [2:0]         sgn;
    logic [2:0][VW-1:0] mag;
    logic [SHW-1:0]     sh;
  } s2_t;

  typedef struct packed {
    logic               v;
    side_t              side;
    logic [2:0]         sgn;
    logic [2:0][MW-1:0] m;
  } s3_t;

  typedef struct packed {
    logic                 v;
    side_t                side;
    logic [2:0]           sgn;
    logic [2:0][MW-1:0]   m;
    logic [2:0][2*MW-1:0] sq;
  } s4_t;

  typedef struct packed {
    logic               v;
    side_t              side;
    logic [2:0]         sgn;
    logic [2:0][MW-1:0] m;
    logic [SUMW-1:0]    x;
    logic [REMW-1:0]    rem;
    logic [SQW-1:0]     root;
  } sq_t;

  typedef struct packed {
    logic                 v;
    side_t                side;
    logic [2:0]           sgn;
    logic [SQW-1:0]       len;
    logic [2:0][NUMW-1:0] rem;
    logic [2:0][QW-1:0]   q;
  } dv_t;

  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;
  s4_t s4_r, s4_nxt;
  sq_t sq_r [SQW+1];
  sq_t sq0_nxt;
  dv_t dv_r [QW+1];
  dv_t dv0_nxt;

  logic                 o_v_r;
  logic signed [UW-1:0] o_vec_r [3];
  side_t                o_side_r;

  // magnitudes and their maximum
  always_comb begin
    s1_nxt.v    = in_v;
    s1_nxt.side = in_side;
    for (int i = 0; i < 3; i++) begin
      s1_nxt.sgn[i] = in_vec[i][VW-1];
      s1_nxt.mag[i] = in_vec[i][VW-1] ? VW'(-in_vec[i]) : VW'(in_vec[i]);
    end
    s1_nxt.mx = s1_nxt.mag[0];
    if (s1_nxt.mag[1] > s1_nxt.mx) s1_nxt.mx = s1_nxt.mag[1];
    if (s1_nxt.mag[2] > s1_nxt.mx) s1_nxt.mx = s1_nxt.mag[2];
  end

  // range shift count from the top set bit of the maximum
  always_comb begin
    logic [SHW-1:0] hb;
    hb = '0;
    for (int i = 0; i < VW; i++) begin
      if (s1_r.mx[i]) hb = SHW'(i);
    end
    s2_nxt.v    = s1_r.v;
    s2_nxt.side = s1_r.side;
    s2_nxt.sgn  = s1_r.sgn;
    s2_nxt.mag  = s1_r.mag;
    s2_nxt.sh   = (hb >= SHW'(MW)) ? SHW'(hb - SHW'(MW - 1)) : '0;
  end

  // apply the shift
  always_comb begin
    s3_nxt.v    = s2_r.v;
    s3_nxt.side = s2_r.side;
    s3_nxt.sgn  = s2_r.sgn;
    for (int i = 0; i < 3; i++) begin
      s3_nxt.m[i] = MW'(s2_r.mag[i] >> s2_r.sh);
    end
  end

  // squares
  always_comb begin
    s4_nxt.v    = s3_r.v;
    s4_nxt.side = s3_r.side;
    s4_nxt.sgn  = s3_r.sgn;
    s4_nxt.m    = s3_r.m;
    for (int i = 0; i < 3; i++) begin
      s4_nxt.sq[i] = s3_r.m[i] * s3_r.m[i];
    end
  end

  // sum of squares, zero vector flag
  always_comb begin
    sq0_nxt.v          = s4_r.v;
    sq0_nxt.side       = s4_r.side;
    sq0_nxt.sgn        = s4_r.sgn;
    sq0_nxt.m          = s4_r.m;
    sq0_nxt.x          = SUMW'(s4_r.sq[0]) + SUMW'(s4_r.sq[1]) + SUMW'(s4_r.sq[2]);
    sq0_nxt.rem        = '0;
    sq0_nxt.root       = '0;
    sq0_nxt.side.degen = s4_r.side.degen | (sq0_nxt.x == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r     <= '0;
      s2_r     <= '0;
      s3_r     <= '0;
      s4_r     <= '0;
      sq_r[0]  <= '0;
    end else if (en) begin
      s1_r     <= s1_nxt;
      s2_r     <= s2_nxt;
      s3_r     <= s3_nxt;
      s4_r     <= s4_nxt;
      sq_r[0]  <= sq0_nxt;
    end
  end

  // square root, one result bit per stage
  for (genvar j = 0; j < SQW; j++) begin : g_sqrt
    sq_t st_nxt;
    always_comb begin
      logic [REMW-1:0] r4;
      logic [REMW-1:0] trial;
      st_nxt = sq_r[j];
      r4     = {sq_r[j].rem[REMW-3:0], sq_r[j].x[2*(SQW-1-j)+1 -: 2]};
      trial  = REMW'({sq_r[j].root, 2'b01});
      if (r4 >= trial) begin
        st_nxt.rem  = r4 - trial;
        st_nxt.root = {sq_r[j].root[SQW-2:0], 1'b1};
      end else begin
        st_nxt.rem  = r4;
        st_nxt.root = {sq_r[j].root[SQW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) sq_r[j+1] <= '0;
      else if (en) sq_r[j+1] <= st_nxt;
    end
  end

  // dividend setup: (m << FRAC_BITS) + len / 2
  always_comb begin
    dv0_nxt.v    = sq_r[SQW].v;
    dv0_nxt.side = sq_r[SQW].side;
    dv0_nxt.sgn  = sq_r[SQW].sgn;
    dv0_nxt.len  = sq_r[SQW].root;
    dv0_nxt.q    = '0;
    for (int i = 0; i < 3; i++) begin
      dv0_nxt.rem[i] = NUMW'({sq_r[SQW].m[i], {FRAC_BITS{1'b0}}})
                     + NUMW'(sq_r[SQW].root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= '0;
    else if (en) dv_r[0] <= dv0_nxt;
  end

  // restoring divide, one quotient bit per stage in each lane
  for (genvar s = 0; s < QW; s++) begin : g_div
    dv_t st_nxt;
    always_comb begin
      logic [NUMW-1:0] dsr;
      st_nxt = dv_r[s];
      dsr    = NUMW'(dv_r[s].len) << (QW - 1 - s);
      for (int i = 0; i < 3; i++) begin
        if (dv_r[s].rem[i] >= dsr) begin
          st_nxt.rem[i]         = dv_r[s].rem[i] - dsr;
          st_nxt.q[i][QW-1-s]   = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[s+1] <= '0;
      else if (en) dv_r[s+1] <= st_nxt;
    end
  end

  // restore signs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r    <= 1'b0;
      o_side_r <= '0;
      for (int i = 0; i < 3; i++) o_vec_r[i] <= '0;
    end else if (en) begin
      o_v_r    <= dv_r[QW].v;
      o_side_r <= dv_r[QW].side;
      for (int i = 0; i < 3; i++) begin
        o_vec_r[i] <= dv_r[QW].sgn[i] ? -$signed(UW'(dv_r[QW].q[i]))
                                      : $signed(UW'(dv_r[QW].q[i]));
      end
    end
  end

  assign out_v    = o_v_r;
  assign out_side = o_side_r;
  assign out_vec  = o_vec_r;

endmodule

### rtl/cvf_proj.sv
// removes the axis component from the unit offset: dot product, rescale,
// subtract; uses cvf_pkg
module cvf_proj import cvf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  cfg_t                 cfg,
  input  logic                 in_v,
  input  logic signed [UW-1:0] in_u [3],
  input  side_t                in_side,
  output logic                 out_v,
  output logic signed [VW-1:0] out_r [3],
  output side_t                out_side
);

  logic signed [W-1:0] ax [3];

  logic [4:0]           v_r;
  side_t                side_r [5];
  logic signed [UW-1:0] u_r [4][3];
  logic signed [PW-1:0] pu_r [3];
  logic signed [63:0]   s_r;
  logic signed [W-1:0]  dot_r;
  logic signed [63:0]   pd_r [3];
  logic signed [VW-1:0] r_r [3];

  assign ax[0] = cfg.ax;
  assign ax[1] = cfg.ay;
  assign ax[2] = cfg.az;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int s = 1; s < 5; s++) side_r[s] <= side_r[s-1];
      for (int i = 0; i < 3; i++) begin
        u_r[0][i] <= in_u[i];
        for (int s = 1; s < 4; s++) u_r[s][i] <= u_r[s-1][i];
        // unit times axis
        pu_r[i] <= in_u[i] * ax[i];
        // dot times axis
        pd_r[i] <= 64'(dot_r) * 64'(ax[i]);
        // radial remainder
        r_r[i]  <= VW'(64'(u_r[3][i]) - rnd_q(pd_r[i]));
      end
      // dot product sum and rounding
      s_r   <= 64'(pu_r[0]) + 64'(pu_r[1]) + 64'(pu_r[2]);
      dot_r <= sat32(rnd_q(s_r));
    end
  end

  assign out_v    = v_r[4];
  assign out_side = side_r[4];
  assign out_r    = r_r;

endmodule

### rtl/cvf_force.sv
// cross product with the axis, scaling, axis mask and saturating
// accumulate; uses cvf_pkg
module cvf_force import cvf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  cfg_t                 cfg,
  input  logic                 in_v,
  input  logic signed [UW-1:0] in_n [3],
  input  side_t                in_side,
  output logic                 out_v,
  output logic signed [W-1:0]  out_acc [3],
  output logic                 out_degen
);

  logic [5:0]           v_r;
  side_t                side_r [5];
  logic signed [PW-1:0] cp_r [6];
  logic signed [63:0]   df_r [3];
  logic signed [W-1:0]  t_r [3];
  logic signed [63:0]   tk_r [3];
  logic signed [W-1:0]  f_r [3];
  logic signed [W-1:0]  acc_r [3];
  logic                 degen_r;
  logic signed [W-1:0]  acc_in [3];

  assign acc_in[0] = side_r[4].acc_x;
  assign acc_in[1] = side_r[4].acc_y;
  assign acc_in[2] = side_r[4].acc_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int s = 1; s < 5; s++) side_r[s] <= side_r[s-1];
      // cross product partial terms
      cp_r[0] <= in_n[1] * cfg.az;
      cp_r[1] <= in_n[2] * cfg.ay;
      cp_r[2] <= in_n[2] * cfg.ax;
      cp_r[3] <= in_n[0] * cfg.az;
      cp_r[4] <= in_n[0] * cfg.ay;
      cp_r[5] <= in_n[1] * cfg.ax;
      for (int i = 0; i < 3; i++) begin
        df_r[i] <= 64'(cp_r[2*i]) - 64'(cp_r[2*i+1]);
        t_r[i]  <= sat32(rnd_q(df_r[i]));
        tk_r[i] <= 64'(t_r[i]) * 64'(side_r[2].k);
        // masked axes and degenerate particles get no force
        f_r[i]  <= (cfg.en_axes[i] && !side_r[3].degen) ? sat32(rnd_q(tk_r[i])) : '0;
        acc_r[i] <= sat32(64'(acc_in[i]) + 64'(f_r[i]));
      end
      degen_r <= side_r[4].degen;
    end
  end

  assign out_v     = v_r[5];
  assign out_acc   = acc_r;
  assign out_degen = degen_r;

endmodule

### dv/tb.sv
// testbench for cylinder_vortex_force_core: scoreboard class with its own
// fixed point predictor, random particle stimulus with random input gaps and random result side stalls
// depends on rtl/cvf_pkg.sv and the core's rtl
`timescale 1ns / 100ps

module tb;
  import cvf_pkg::*;

  localparam int LIMIT = 600000;

  typedef struct {
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic signed [W-1:0] z;
    logic                degen;
  } force_word_t;

  // predicts the accumulator update for each live particle
  class vortex_scoreboard;
    longint         coef, ax[3], ctr[3];
    logic [2:0]     axes;
    force_word_t    pending[$];
    int             errors;

    function new();
      coef = 65536; ax[0] = 0; ax[1] = 0; ax[2] = 65536;
      ctr[0] = 0; ctr[1] = 0; ctr[2] = 0; axes = 3'b111; errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [W-1:0] v);
      case (idx)
        REG_COEF:   coef = longint'($signed(v));
        REG_AXIS_X: ax[0] = longint'($signed(v));
        REG_AXIS_Y: ax[1] = longint'($signed(v));
        REG_AXIS_Z: ax[2] = longint'($signed(v));
        REG_CTR_X:  ctr[0] = longint'($signed(v));
        REG_CTR_Y:  ctr[1] = longint'($signed(v));
        REG_CTR_Z:  ctr[2] = longint'($signed(v));
        REG_AXES:   axes = v[2:0];
        default: ;
      endcase
    endfunction

    function longint rnd(longint v);
      longint m;
      m = v < 0 ? -v : v;
      m = (m + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      return v < 0 ? -m : m;
    endfunction

    function longint clamp(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint unsigned root(longint unsigned x);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // unit vector; returns 0 for the zero vector
    function bit unit(longint v[3], output longint o[3]);
      longint unsigned m[3], mx, sum, len, q;
      mx = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = v[i] < 0 ? -v[i] : v[i];
        if (m[i] > mx) mx = m[i];
      end
      while (mx >= (64'd1 << 30)) begin
        mx = mx >> 1;
        for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      end
      for (int i = 0; i < 3; i++) sum += m[i] * m[i];
      for (int i = 0; i < 3; i++) o[i] = 0;
      if (sum == 0) return 0;
      len = root(sum);
      for (int i = 0; i < 3; i++) begin
        q = ((m[i] << FRAC_BITS) + len / 2) / len;
        o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1;
    endfunction

    // note an accepted input word
    function void note_particle(logic alive, logic signed [W-1:0] p[3],
                                logic signed [W-1:0] str, logic signed [W-1:0] a[3]);
      longint acc[3], d[3], u[3], r[3], n[3], t[3], dot, k;
      force_word_t e;
      if (!alive) return;
      e.degen = 1;
      for (int i = 0; i < 3; i++) begin
        acc[i] = a[i];
        d[i] = longint'(p[i]) - ctr[i];
      end
      if (unit(d, u)) begin
        dot = clamp(rnd(u[0] * ax[0] + u[1] * ax[1] + u[2] * ax[2]));
        for (int i = 0; i < 3; i++) r[i] = u[i] - rnd(dot * ax[i]);
        if (unit(r, n)) begin
          e.degen = 0;
          t[0] = clamp(rnd(n[1] * ax[2] - n[2] * ax[1]));
          t[1] = clamp(rnd(n[2] * ax[0] - n[0] * ax[2]));
          t[2] = clamp(rnd(n[0] * ax[1] - n[1] * ax[0]));
          k = clamp(rnd(longint'(str) * coef));
          for (int i = 0; i < 3; i++)
            if (axes[i]) acc[i] = clamp(acc[i] + clamp(rnd(t[i] * k)));
        end
      end
      e.x = acc[0][31:0];
      e.y = acc[1][31:0];
      e.z = acc[2][31:0];
      pending.push_back(e);
    endfunction

    // compare a result word with the oldest expectation
    function void check_result(force_word_t got);
      force_word_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.x !== e.x) begin
        $error("acc_out_x expected %0d got %0d", e.x, got.x); errors++;
      end
      if (got.y !== e.y) begin
        $error("acc_out_y expected %0d got %0d", e.y, got.y); errors++;
      end
      if (got.z !== e.z) begin
        $error("acc_out_z expected %0d got %0d", e.z, got.z); errors++;
      end
      if (got.degen !== e.degen) begin
        $error("degenerate expected %0b got %0b", e.degen, got.degen); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [W-1:0] cfg_wdata;
  logic in_valid, in_stall, in_alive;
  logic signed [W-1:0] in_pos_x, in_pos_y, in_pos_z, in_strength;
  logic signed [W-1:0] in_acc_in_x, in_acc_in_y, in_acc_in_z;
  logic out_valid, out_stall, out_degenerate;
  logic signed [W-1:0] out_acc_out_x, out_acc_out_y, out_acc_out_z;

  vortex_scoreboard sb;
  int cycles;
  int stall_mode;
  bit gaps_on;
  longint cur_ax[3], cur_ctr[3];

  cylinder_vortex_force_core dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n = 0; cfg_we = 0; cfg_index = REG_COEF; cfg_wdata = '0;
    in_valid = 0; in_alive = 0; in_pos_x = 0; in_pos_y = 0; in_pos_z = 0;
    in_strength = 0; in_acc_in_x = 0; in_acc_in_y = 0; in_acc_in_z = 0;
    out_stall = 0; stall_mode = 0;
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side stalls: bursts, mostly short
  always @(posedge clk) begin
    if (stall_mode == 0) out_stall <= 0;
    else if (stall_mode == 1) out_stall <= ($urandom_range(0, 99) < 25);
    else out_stall <= ($urandom_range(0, 99) < 85);
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
  end

  // input and result monitors
  always @(posedge clk) begin
    logic signed [W-1:0] p[3], a[3];
    force_word_t got;
    if (rst_n && in_valid && !in_stall) begin
      p[0] = in_pos_x; p[1] = in_pos_y; p[2] = in_pos_z;
      a[0] = in_acc_in_x; a[1] = in_acc_in_y; a[2] = in_acc_in_z;
      sb.note_particle(in_alive, p, in_strength, a);
    end
    if (rst_n && out_valid && !out_stall) begin
      got.x = out_acc_out_x; got.y = out_acc_out_y; got.z = out_acc_out_z;
      got.degen = out_degenerate;
      sb.check_result(got);
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // drive one particle word, wait for acceptance, then maybe leave a random gap
  task automatic send_particle(logic alive, logic signed [W-1:0] px, logic signed [W-1:0] py,
                               logic signed [W-1:0] pz, logic signed [W-1:0] str,
                               logic signed [W-1:0] ax_, logic signed [W-1:0] ay_,
                               logic signed [W-1:0] az_);
    int g;
    in_valid <= 1; in_alive <= alive;
    in_pos_x <= px; in_pos_y <= py; in_pos_z <= pz; in_strength <= str;
    in_acc_in_x <= ax_; in_acc_in_y <= ay_; in_acc_in_z <= az_;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  // wait for every expected word, then let the pipeline drain dropped words
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
  endtask

  task automatic write_regs(logic [W-1:0] coef, logic [W-1:0] axx, logic [W-1:0] axy,
                            logic [W-1:0] axz, logic [W-1:0] cxx, logic [W-1:0] cyy,
                            logic [W-1:0] czz, logic [2:0] en);
    logic [W-1:0] v[8];
    v[REG_COEF] = coef; v[REG_AXIS_X] = axx; v[REG_AXIS_Y] = axy; v[REG_AXIS_Z] = axz;
    v[REG_CTR_X] = cxx; v[REG_CTR_Y] = cyy; v[REG_CTR_Z] = czz; v[REG_AXES] = {29'd0, en};
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1; cfg_index <= 3'(i); cfg_wdata <= v[i];
      sb.set_reg(3'(i), v[i]);
      @(posedge clk);
    end
    cfg_we <= 0;
    @(posedge clk);
    cur_ax[0] = $signed(axx); cur_ax[1] = $signed(axy); cur_ax[2] = $signed(axz);
    cur_ctr[0] = $signed(cxx); cur_ctr[1] = $signed(cyy); cur_ctr[2] = $signed(czz);
  endtask

  function automatic logic [W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
      3, 4: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  // random particle: mostly near the centre or along the axis, some noise
  task automatic send_random();
    logic signed [W-1:0] p[3];
    longint t;
    int kind;
    kind = $urandom_range(0, 19);
    t = longint'($signed($urandom_range(0, 64))) - 32;
    for (int i = 0; i < 3; i++) begin
      case (kind)
        0, 1, 2, 3: p[i] = rand_word();
        4: p[i] = cur_ctr[i][31:0];
        5: p[i] = 32'((cur_ctr[i] + ((t * cur_ax[i]) >>> 4)));
        default: p[i] = 32'(cur_ctr[i] + longint'($signed($urandom_range(0, 1 << 21)))
                            - (1 << 20));
      endcase
    end
    send_particle($urandom_range(0, 9) != 0, p[0], p[1], p[2], rand_word(),
                  rand_word(), rand_word(), rand_word());
  endtask

  initial begin
    sb = new();
    cycles = 0;
    gaps_on = 0;
    cur_ax[0] = 0; cur_ax[1] = 0; cur_ax[2] = 65536;
    cur_ctr[0] = 0; cur_ctr[1] = 0; cur_ctr[2] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed words in the reset setting
    send_particle(1, 32'h00010000, 0, 0, 32'h00010000, 0, 0, 0);
    send_particle(1, 0, 0, 0, 32'h00010000, 5, -5, 7);           // on the centre
    send_particle(1, 0, 0, 32'h00050000, 32'h00010000, 1, 2, 3); // along the axis
    send_particle(0, 32'h00010000, 0, 0, 32'h00010000, 0, 0, 0); // dead
    send_particle(1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_particle(1, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                  32'h80000000, 32'h80000000, 32'h80000000);
    send_particle(1, 32'h7fffffff, 32'h80000000, 0, 32'h80000000,
                  32'h7fffffff, 32'h80000000, 0);
    send_particle(1, 1, 0, 0, 32'h00010000, 0, 0, 0);
    send_particle(1, 0, 32'hffffffff, 1, 32'h7fffffff, 32'h7fff0000, 0, 0);
    send_particle(1, 32'hffff0000, 32'h00010000, 32'h80000000, 32'hffff0000, 0, 0, 0);
    drain();

    // directed words with an unnormalized axis and off-centre vortex
    write_regs(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
               32'h80000000, 32'h7fffffff, 32'h80000000, 3'b101);
    send_particle(1, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, 0, 0);
    send_particle(1, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h00010000, 0, 0, 0);
    send_particle(1, 0, 0, 0, 32'h80000000, 32'h7fffffff, 0, 32'h80000000);
    send_particle(1, 32'h12345678, 32'h9abcdef0, 32'h0fedcba9, 32'h00020000, 0, 0, 0);
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: write_regs(32'h00010000, 0, 0, 32'h00010000, 0, 0, 0, 3'b111);
        1: write_regs(32'h00028000, 32'd39322, 32'd52429, 0,
                      32'h00100000, 32'hfff00000, 32'h00030000, 3'b011);
        2: write_regs(32'h7fffffff, 32'h00010000, 0, 0, 32'h7fffffff, 0, 32'h80000000, 3'b110);
        3: write_regs(32'h80000000, 0, 32'hffff0000, 0, 0, 32'h80000000, 0, 3'b000);
        4: write_regs($urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, 3'($urandom));
        5: write_regs(32'hffff8000, 32'd37837, 32'd37837, 32'd37837,
                      32'h00008000, 32'h00008000, 32'hffff8000, 3'b111);
        default: write_regs(32'h00000001, 0, 0, 32'hffff0000, 32'h01000000, 0, 0, 3'b100);
      endcase
      gaps_on = (ph != 2);
      for (int n = 0; n < 255; n++) send_random();
      drain();
    end

    if (sb.pending.size() != 0) begin
      $error("expected words left over");
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
rtl/cvf_pkg.sv
rtl/cvf_norm.sv
rtl/cvf_proj.sv
rtl/cvf_force.sv
rtl/cylinder_vortex_force_core.sv
dv/tb.sv
